/* src/lrs_pkg.sv */
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants of the record store
// Slot layout, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package lrs_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int KEPT_IDS   = 32;

	localparam int AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW    = $clog2(SLOT_COUNT + 1);
	localparam int KW    = (KEPT_IDS > 1) ? $clog2(KEPT_IDS) : 1;
	localparam int KCW   = $clog2(KEPT_IDS + 1);
	localparam int THR_W = 9;
	localparam int CMP_W = (CW > THR_W) ? CW : THR_W;

	localparam logic [7:0]       FREE_KEY  = 8'hFF;
	localparam logic [THR_W-1:0] THR_RESET = 9'd16;

	// one slot as stored
	typedef struct packed {
		logic [7:0]  key;
		logic [15:0] sum;
		logic [39:0] high;
		logic [63:0] low;
	} slot_t;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SAVE    = 2'd1,
		OP_COMPACT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_SKIPPED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_FILL = 2'd2,
		S_DONE = 2'd3
	} state_t;

endpackage

/* src/log_record_store_with_compaction_unit.sv */
// ----------------------------------------------------------------------------
// log_record_store_with_compaction_unit
// Append-only record store with load, save and compaction.
// ----------------------------------------------------------------------------
// Usage:
//  Input words arrive on s_axis (tuser = operation, tdata = key and record),
//  one result word per input leaves on m_axis (tuser = status, tdata = found
//  record and free slot count). cfg_we/cfg_wdata write the compaction
//  threshold; write it only while the block is idle.
//  Slots are always filled from slot 0 upward, so a fill count marks which
//  slots are in use; slots at or above it read as erased. Slot state sits in
//  one single-port-write memory with a registered read.
//  Save and no-op go straight from idle to the result register. Load scans
//  the used slots (at most SLOT_COUNT), one memory read per cycle.
//  Compaction scans the same way, then rewrites up to KEPT_IDS records from
//  the gather buffer. A skipped compaction goes straight to the result
//  register. One item is in work at a time.
//  Reset empties the store (fill count zero) and sets the threshold to 16;
//  no clearing pass is needed. When the receiver stalls, the result holds in
//  the output register and the next item may still be accepted and worked;
//  it waits for the output register to free up before finishing.
// ----------------------------------------------------------------------------
module log_record_store_with_compaction_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// key[7:0], payload_low[71:8], payload_high[111:72], record_sum[127:112]
	input  logic [127:0] s_axis_tdata,
	// operation[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found_key[7:0], found_payload_low[71:8], found_payload_high[111:72],
	// found_sum[127:112], free_slots[136:128], zero pad[143:137]
	output logic [143:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [8:0]   cfg_wdata
);

	lrs_pkg::state_t state_q, state_nxt;

	logic [lrs_pkg::THR_W-1:0] thr_q;
	logic [lrs_pkg::CW-1:0]    fill_q;
	logic [lrs_pkg::CW-1:0]    scan_cnt_q;
	logic [lrs_pkg::KCW-1:0]   kcnt_q;
	logic [lrs_pkg::KEPT_IDS-1:0] bvalid_q;
	logic                      is_load_q;
	logic [7:0]                req_key_q;

	// result being built
	lrs_pkg::status_t res_status_q;
	lrs_pkg::slot_t   res_q;

	// memories
	lrs_pkg::slot_t slot_mem [lrs_pkg::SLOT_COUNT];
	lrs_pkg::slot_t buf_mem  [lrs_pkg::KEPT_IDS];
	lrs_pkg::slot_t rd_data_s1;
	logic           rd_vld_s1;
	lrs_pkg::slot_t buf_data_s1;
	logic           buf_vld_s1;

	// control strobes
	logic in_fire, scan_issue, scan_done, fill_issue, fill_done, out_load;

	logic [lrs_pkg::CMP_W-1:0] free_now;
	logic                      store_full;
	lrs_pkg::op_t              in_op;
	lrs_pkg::slot_t            in_rec;

	logic                      wr_en;
	logic [lrs_pkg::AW-1:0]    wr_addr;
	lrs_pkg::slot_t            wr_data;

	assign in_op  = lrs_pkg::op_t'(s_axis_tuser);
	assign in_rec = lrs_pkg::slot_t'({s_axis_tdata[7:0], s_axis_tdata[127:112],
		s_axis_tdata[111:72], s_axis_tdata[71:8]});

	assign free_now   = lrs_pkg::CMP_W'(lrs_pkg::SLOT_COUNT) - lrs_pkg::CMP_W'(fill_q);
	assign store_full = (fill_q == lrs_pkg::CW'(lrs_pkg::SLOT_COUNT));

	// control outputs
	always_comb begin
		s_axis_tready = (state_q == lrs_pkg::S_IDLE);
		in_fire       = s_axis_tvalid && s_axis_tready;
		scan_issue    = (state_q == lrs_pkg::S_SCAN) && (scan_cnt_q < fill_q);
		scan_done     = (state_q == lrs_pkg::S_SCAN) && !scan_issue && !rd_vld_s1;
		fill_issue    = (state_q == lrs_pkg::S_FILL) &&
			(kcnt_q < lrs_pkg::KCW'(lrs_pkg::KEPT_IDS));
		fill_done     = (state_q == lrs_pkg::S_FILL) && !fill_issue && !buf_vld_s1;
		out_load      = (state_q == lrs_pkg::S_DONE) && (!m_axis_tvalid || m_axis_tready);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lrs_pkg::S_IDLE: begin
				if (in_fire) begin
					if (in_op == lrs_pkg::OP_LOAD) begin
						state_nxt = lrs_pkg::S_SCAN;
					end else if (in_op == lrs_pkg::OP_COMPACT &&
						free_now < lrs_pkg::CMP_W'(thr_q)) begin
						state_nxt = lrs_pkg::S_SCAN;
					end else begin
						state_nxt = lrs_pkg::S_DONE;
					end
				end
			end
			lrs_pkg::S_SCAN: begin
				if (scan_done) state_nxt = is_load_q ? lrs_pkg::S_DONE : lrs_pkg::S_FILL;
			end
			lrs_pkg::S_FILL: begin
				if (fill_done) state_nxt = lrs_pkg::S_DONE;
			end
			lrs_pkg::S_DONE: begin
				if (out_load) state_nxt = lrs_pkg::S_IDLE;
			end
			default: state_nxt = lrs_pkg::S_IDLE;
		endcase
	end

	// slot memory write port: saves in idle, rewrites in fill
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q[lrs_pkg::AW-1:0];
		wr_data = in_rec;
		if (in_fire && in_op == lrs_pkg::OP_SAVE && !store_full &&
			in_rec.key != lrs_pkg::FREE_KEY) begin
			wr_en = 1'b1;
		end else if (buf_vld_s1) begin
			wr_en   = 1'b1;
			wr_data = buf_data_s1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (wr_en) slot_mem[wr_addr] <= wr_data;
		rd_data_s1 <= slot_mem[scan_cnt_q[lrs_pkg::AW-1:0]];
		if (rd_vld_s1 && !is_load_q && rd_data_s1.key < 8'(lrs_pkg::KEPT_IDS)) begin
			buf_mem[rd_data_s1.key[lrs_pkg::KW-1:0]] <= rd_data_s1;
		end
		buf_data_s1 <= buf_mem[kcnt_q[lrs_pkg::KW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lrs_pkg::S_IDLE;
			thr_q         <= lrs_pkg::THR_RESET;
			fill_q        <= '0;
			scan_cnt_q    <= '0;
			kcnt_q        <= '0;
			bvalid_q      <= '0;
			rd_vld_s1     <= 1'b0;
			buf_vld_s1    <= 1'b0;
			is_load_q     <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) thr_q <= cfg_wdata;

			// accept
			if (in_fire) begin
				scan_cnt_q <= '0;
				kcnt_q     <= '0;
				bvalid_q   <= '0;
				is_load_q  <= (in_op == lrs_pkg::OP_LOAD);
				if (in_op == lrs_pkg::OP_SAVE && !store_full &&
					in_rec.key != lrs_pkg::FREE_KEY) begin
					fill_q <= fill_q + 1'b1;
				end
			end

			// scan reads
			rd_vld_s1 <= scan_issue;
			if (scan_issue) scan_cnt_q <= scan_cnt_q + 1'b1;
			if (rd_vld_s1 && !is_load_q && rd_data_s1.key < 8'(lrs_pkg::KEPT_IDS)) begin
				bvalid_q[rd_data_s1.key[lrs_pkg::KW-1:0]] <= 1'b1;
			end

			// erase at end of gather, then rewrite in key order
			if (scan_done && !is_load_q) fill_q <= '0;
			buf_vld_s1 <= fill_issue && bvalid_q[kcnt_q[lrs_pkg::KW-1:0]];
			if (fill_issue) kcnt_q <= kcnt_q + 1'b1;
			if (buf_vld_s1) fill_q <= fill_q + 1'b1;

			// output register
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_key_q <= in_rec.key;
			res_q     <= lrs_pkg::slot_t'({lrs_pkg::FREE_KEY, 120'd0});
			case (in_op)
				lrs_pkg::OP_LOAD:    res_status_q <= lrs_pkg::ST_NOT_FOUND;
				lrs_pkg::OP_SAVE:    res_status_q <= store_full ? lrs_pkg::ST_FULL
					: lrs_pkg::ST_OK;
				lrs_pkg::OP_COMPACT: res_status_q <= (free_now < lrs_pkg::CMP_W'(thr_q))
					? lrs_pkg::ST_OK : lrs_pkg::ST_SKIPPED;
				default:             res_status_q <= lrs_pkg::ST_OK;
			endcase
		end
		// last match wins
		if (rd_vld_s1 && is_load_q && rd_data_s1.key == req_key_q) begin
			res_q        <= rd_data_s1;
			res_status_q <= lrs_pkg::ST_OK;
		end
		if (out_load) begin
			m_axis_tdata <= {7'd0, free_now[lrs_pkg::THR_W-1:0], res_q.sum, res_q.high,
				res_q.low, res_q.key};
			m_axis_tuser <= res_status_q;
		end
	end

	// checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lrs_pkg::CW'(lrs_pkg::SLOT_COUNT)) else $error("fill count overflow");
	a_rewrite_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lrs_pkg::S_FILL |-> fill_q <= lrs_pkg::CW'(lrs_pkg::KEPT_IDS))
		else $error("rewrite overran kept keys");
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == lrs_pkg::S_SCAN) else $error("slot read outside scan");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != lrs_pkg::S_IDLE) else $error("item accepted with no work");

endmodule

/* tb/sv/lrs_result_checker.sv */
// ----------------------------------------------------------------------------
// lrs_result_checker
// Watches both stream channels of the record store, keeps its own copy of
// the slots and the threshold, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module lrs_result_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [143:0] m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [8:0]   cfg_wdata,
	output int           fail_count,
	output int           pending_count,
	output int           result_count
);

	typedef struct packed {
		lrs_pkg::status_t status;
		logic [8:0]       free_slots;
		logic [15:0]      sum;
		logic [39:0]      high;
		logic [63:0]      low;
		logic [7:0]       key;
	} result_t;

	lrs_pkg::slot_t store [lrs_pkg::SLOT_COUNT];
	logic [8:0]     threshold;
	result_t        expected_results [$];
	int             count_by_status [4];

	function automatic int free_count();
		int n;
		n = 0;
		for (int i = 0; i < lrs_pkg::SLOT_COUNT; i++)
			if (store[i].key == lrs_pkg::FREE_KEY) n++;
		return n;
	endfunction

	function automatic int last_slot_of(logic [7:0] key);
		int hit;
		hit = -1;
		if (key == lrs_pkg::FREE_KEY) return -1;
		for (int i = 0; i < lrs_pkg::SLOT_COUNT; i++)
			if (store[i].key == key) hit = i;
		return hit;
	endfunction

	function automatic void erase_store();
		for (int i = 0; i < lrs_pkg::SLOT_COUNT; i++) store[i] = '1;
	endfunction

	function automatic bit append_slot(lrs_pkg::slot_t rec);
		for (int i = 0; i < lrs_pkg::SLOT_COUNT; i++)
			if (store[i].key == lrs_pkg::FREE_KEY) begin
				if (rec.key != lrs_pkg::FREE_KEY) store[i] = rec;
				return 1;
			end
		return 0;
	endfunction

	// work out the result word of one accepted input word
	function automatic result_t predict_result(lrs_pkg::op_t op, logic [127:0] d);
		result_t        r;
		lrs_pkg::slot_t rec;
		lrs_pkg::slot_t kept [lrs_pkg::KEPT_IDS];
		int             s;
		r = '0;
		r.key = 8'hFF;
		r.status = lrs_pkg::ST_OK;
		rec.key = d[7:0];
		rec.low = d[71:8];
		rec.high = d[111:72];
		rec.sum = d[127:112];
		case (op)
			lrs_pkg::OP_LOAD: begin
				s = last_slot_of(rec.key);
				if (s < 0) r.status = lrs_pkg::ST_NOT_FOUND;
				else begin
					r.key = store[s].key;
					r.low = store[s].low;
					r.high = store[s].high;
					r.sum = store[s].sum;
				end
			end
			lrs_pkg::OP_SAVE: begin
				if (!append_slot(rec)) r.status = lrs_pkg::ST_FULL;
			end
			lrs_pkg::OP_COMPACT: begin
				if (free_count() >= threshold) r.status = lrs_pkg::ST_SKIPPED;
				else begin
					for (int k = 0; k < lrs_pkg::KEPT_IDS; k++) begin
						s = last_slot_of(k[7:0]);
						kept[k] = (s >= 0) ? store[s] : '1;
					end
					erase_store();
					for (int k = 0; k < lrs_pkg::KEPT_IDS; k++)
						if (kept[k].key != lrs_pkg::FREE_KEY) void'(append_slot(kept[k]));
				end
			end
			default: ;
		endcase
		r.free_slots = 9'(free_count());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			erase_store();
			threshold <= lrs_pkg::THR_RESET;
			fail_count <= 0;
			result_count <= 0;
			expected_results.delete();
			for (int i = 0; i < 4; i++) count_by_status[i] = 0;
		end else begin
			if (cfg_we) threshold <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(
					predict_result(lrs_pkg::op_t'(s_axis_tuser), s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.key = m_axis_tdata[7:0];
				got.low = m_axis_tdata[71:8];
				got.high = m_axis_tdata[111:72];
				got.sum = m_axis_tdata[127:112];
				got.free_slots = m_axis_tdata[136:128];
				got.status = lrs_pkg::status_t'(m_axis_tuser);
				result_count <= result_count + 1;
				count_by_status[m_axis_tuser]++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word status=%0d key=%0d",
						$time, got.status, got.key);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want || m_axis_tdata[143:137] !== '0) begin
						$display("%0t: mismatch expected st=%0d key=%h low=%h high=%h sum=%h free=%0d",
							$time, want.status, want.key, want.low, want.high, want.sum,
							want.free_slots);
						$display("%0t:          actual   st=%0d key=%h low=%h high=%h sum=%h free=%0d",
							$time, got.status, got.key, got.low, got.high, got.sum,
							got.free_slots);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending_count = expected_results.size();

endmodule

/* tb/sv/log_record_store_with_compaction_unit_test.sv */
// ----------------------------------------------------------------------------
// log_record_store_with_compaction_unit_test
// Drives load, save, compact and no-op words with random gaps and receiver stalls,
// steps the compaction threshold through its range, and lets the checker
// judge every result word.
// ----------------------------------------------------------------------------
module log_record_store_with_compaction_unit_test;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [143:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_we = 0;
	logic [8:0]   cfg_wdata = '0;
	int           fail_count;
	int           pending_count;
	int           result_count;
	bit           long_stall = 0;
	bit           stall_done = 0;
	int           word_count = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	log_record_store_with_compaction_unit dut (.*);

	lrs_result_checker checker_i (.*);

	// short gaps mostly, a long one now and then
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: random stalls, plus one long hold-off
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall && !stall_done) begin
				m_axis_tready <= 0;
				repeat (400) @(negedge clk);
				stall_done = 1;
			end
			n = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
			if (n > 0) begin
				m_axis_tready <= 0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	task automatic send_word(lrs_pkg::op_t op, logic [7:0] key, logic [63:0] low,
		logic [39:0] high, logic [15:0] sum);
		int n;
		n = gap_length();
		if (n > 0) begin
			s_axis_tvalid <= 0;
			repeat (n) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {sum, high, low, key};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		word_count++;
		@(negedge clk);
	endtask

	task automatic send_random(lrs_pkg::op_t op, logic [7:0] key);
		send_word(op, key, {$urandom, $urandom}, 40'({$urandom, $urandom}),
			16'($urandom));
	endtask

	// wait for all results, settle, then write the threshold
	task automatic set_threshold(logic [8:0] v);
		s_axis_tvalid <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [7:0] random_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 8'($urandom_range(0, lrs_pkg::KEPT_IDS - 1));
		if (r < 9) return 8'($urandom_range(0, 254));
		return 8'hFF;
	endfunction

	initial begin
		logic [8:0]   thresholds [6];
		lrs_pkg::op_t op;
		thresholds = '{9'd16, 9'd0, 9'd256, 9'd511, 9'd100, 9'd1};
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty load, extremes, free key, no-op, a compaction
		send_random(lrs_pkg::OP_LOAD, 8'd0);
		send_word(lrs_pkg::OP_SAVE, 8'd0, '0, '0, '0);
		send_word(lrs_pkg::OP_SAVE, 8'd254, '1, '1, '1);
		send_word(lrs_pkg::OP_SAVE, 8'd0, 64'h0123456789ABCDEF, 40'hA5A5A5A5A5, 16'h5A5A);
		send_random(lrs_pkg::OP_LOAD, 8'd0);
		send_random(lrs_pkg::OP_LOAD, 8'd254);
		send_random(lrs_pkg::OP_LOAD, 8'hFF);
		send_random(lrs_pkg::OP_SAVE, 8'hFF);
		send_random(lrs_pkg::OP_NONE, 8'd3);
		send_random(lrs_pkg::OP_COMPACT, 8'd0);
		send_random(lrs_pkg::OP_LOAD, 8'd0);
		send_random(lrs_pkg::OP_LOAD, 8'd254);

		// phases over thresholds; fill the store so full and compaction happen
		for (int p = 0; p < 6; p++) begin
			set_threshold(thresholds[p]);
			if (p == 1) long_stall = 1;
			for (int i = 0; i < 300; i++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: op = lrs_pkg::OP_SAVE;
					11, 12, 13, 14, 15, 16: op = lrs_pkg::OP_LOAD;
					17, 18: op = lrs_pkg::OP_COMPACT;
					default: op = lrs_pkg::OP_NONE;
				endcase
				send_random(op, random_key());
			end
			send_random(lrs_pkg::OP_SAVE, 8'hFF);
		end
		s_axis_tvalid <= 0;

		while (pending_count != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		$display("Sent %0d words over six threshold settings (0, 1, 16, 100, 256, 511);",
			word_count);
		$display("%0d result words checked: OK %0d, not found %0d, full %0d, skipped %0d",
			result_count, checker_i.count_by_status[0], checker_i.count_by_status[1],
			checker_i.count_by_status[2], checker_i.count_by_status[3]);
		if (fail_count == 0)
			$display("log_record_store_with_compaction_unit_test passed");
		else
			$display("log_record_store_with_compaction_unit_test failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("log_record_store_with_compaction_unit_test failed");
		$finish;
	end

endmodule
